### src/ordered_queue_delete_by_value_assert.svh
// Assertion macros for the ordered queue RTL.
`ifndef ORDERED_QUEUE_DELETE_BY_VALUE_ASSERT_SVH
`define ORDERED_QUEUE_DELETE_BY_VALUE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define OQDBV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define OQDBV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/oqdbv_pkg.sv
// Package: types and constants of the ordered queue with delete by value.
`timescale 1ns / 1ps
`default_nettype none

package oqdbv_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned DATA_W    = 32;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    status_e                   status;
    logic                      last;
  } out_item_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic load_en;  // write value into the first free cell, just past the tail
    logic cmp_en;   // capture the compare result against the key
    logic del_en;   // close the gap behind the first match
    logic rot_en;   // rotate live entries one step toward the head
  } cell_cmd_t;

endpackage

`default_nettype wire

### src/oqdbv_cell.sv
// One queue cell: holds an entry, compares it and takes data from its neighbor.
`timescale 1ns / 1ps
`default_nettype none

module oqdbv_cell import oqdbv_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cell_cmd_t                 cmd_i,
  input  wire logic [CW-1:0]             occ_i,
  input  wire logic signed [DATA_W-1:0]  value_i,
  input  wire logic signed [DATA_W-1:0]  next_entry_i,
  input  wire logic signed [DATA_W-1:0]  head_i,
  input  wire logic                      hit_i,
  output logic                           hit_o,
  output logic signed [DATA_W-1:0]       entry_o
);

  logic signed [DATA_W-1:0] entry_q;
  logic                     match_q;
  logic                     live;
  logic                     is_tail;
  logic                     is_free_slot;

  // Position of this cell relative to the occupancy
  assign live         = CW'(IDX) < occ_i;
  assign is_tail      = CW'(IDX + 1) == occ_i;
  assign is_free_slot = CW'(IDX) == occ_i;

  // A match at or before this cell means this cell moves up
  assign hit_o   = hit_i | match_q;
  assign entry_o = entry_q;

  // Compare flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      match_q <= live && (entry_q == value_i);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && is_free_slot) begin
      entry_q <= value_i;
    end else if (cmd_i.del_en && hit_o) begin
      entry_q <= next_entry_i;
    end else if (cmd_i.rot_en) begin
      entry_q <= is_tail ? head_i : next_entry_i;
    end
  end

endmodule

`default_nettype wire

### src/ordered_queue_delete_by_value.sv
// Ordered queue of signed 32-bit values with append, delete by value and readout.
//
// Usage: an input transfer carries an action and a value on in_item_i
// (in_valid_i / in_stall_o); results leave on out_item_o (out_valid_o /
// out_stall_i) through one output register.
// Append: one result, in the cycle after the transfer (status full when the
// queue already holds DEPTH entries; the value is dropped).
// Delete: one result: the transfer captures the compare in every cell, then
// the S_DEL state, once the output is free, shifts the cells behind the first
// match toward the head, one neighbor step, and lowers the occupancy.
// Readout: one result per entry, head first, one per cycle while the output
// is not stalled, the final one marked last; empty gives one result.
// The row of cells rotates one step per result and is back in order after
// the final one. Action code 3 is taken and gives nothing.
// One item is in work at a time: a delete or readout holds the engine out
// of idle until its last result is emitted.
// A stalled output holds its result and stops the engine; in_stall_o is high
// while an item is in work or the output register cannot take a result.
// Reset empties the queue; entry contents are not cleared and never read.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_queue_delete_by_value_assert.svh"

module ordered_queue_delete_by_value import oqdbv_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEL  = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e        st_q, st_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q;
  out_item_t     emit_item;
  logic          emit;
  logic          out_free;
  logic          in_xfer;
  logic          full;
  cell_cmd_t     cmd;

  logic signed [DATA_W-1:0] entry [DEPTH];
  logic                     hit   [DEPTH+1];

  // Handshake
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((st_q == S_IDLE) && out_free);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign full        = occ_q == CW'(DEPTH);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Row of cells; data moves from cell i+1 into cell i
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] nxt;
    if (i == DEPTH - 1) begin : g_end
      assign nxt = entry[i];
    end else begin : g_mid
      assign nxt = entry[i+1];
    end
    oqdbv_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .occ_i        (occ_q),
      .value_i      (in_item_i.value),
      .next_entry_i (nxt),
      .head_i       (entry[0]),
      .hit_i        (hit[i]),
      .hit_o        (hit[i+1]),
      .entry_o      (entry[i])
    );
  end

  // Sequencer
  always_comb begin
    st_d      = st_q;
    occ_d     = occ_q;
    cnt_d     = cnt_q;
    cmd       = '0;
    emit      = 1'b0;
    emit_item = '{data: '0, status: ST_OK, last: 1'b1};
    case (st_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_item_i.action)
            ACT_APPEND: begin
              emit = 1'b1;
              if (full) begin
                emit_item.status = ST_FULL;
              end else begin
                cmd.load_en = 1'b1;
                occ_d       = occ_q + 1'b1;
              end
            end
            ACT_DELETE: begin
              cmd.cmp_en = 1'b1;
              st_d       = S_DEL;
            end
            ACT_READ: begin
              if (occ_q == '0) begin
                emit             = 1'b1;
                emit_item.status = ST_EMPTY;
              end else begin
                cnt_d = '0;
                st_d  = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL: begin
        if (out_free) begin
          emit = 1'b1;
          if (hit[DEPTH]) begin
            cmd.del_en = 1'b1;
            occ_d      = occ_q - 1'b1;
          end else begin
            emit_item.status = ST_NOT_FOUND;
          end
          st_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          emit           = 1'b1;
          cmd.rot_en     = 1'b1;
          emit_item.data = entry[0];
          emit_item.last = (cnt_q + 1'b1) == occ_q;
          cnt_d          = cnt_q + 1'b1;
          if (emit_item.last) begin
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Output register
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  // Checks
  `OQDBV_ASSERT_ALWAYS(a_occ_bound, !rst_ni || (occ_q <= CW'(DEPTH)), "occupancy above depth")
  `OQDBV_ASSERT(a_read_occ_stable, (st_q == S_READ) |=> $stable(occ_q), "occupancy moved in readout")
  `OQDBV_ASSERT(a_read_cnt, (st_q == S_READ) |-> (cnt_q < occ_q), "readout count past occupancy")
  `OQDBV_ASSERT(a_append_grow, (in_xfer && (in_item_i.action == ACT_APPEND) && !full) |=> (occ_q == $past(occ_q) + 1'b1), "append did not grow queue")

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the ordered queue with append, delete by value and readout.
`timescale 1ns / 1ps

module tb;
  import oqdbv_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
  localparam int QUIET_LIMIT = 4000;  // cycles without any transfer before giving up
  localparam int TAIL_CYCLES = 40;    // settle time after the last expected result, in cycles
  localparam int REPORT_MAX  = 30;    // mismatch lines printed before going quiet

  typedef struct {
    in_item_t item;
    bit       wait_drained;  // hold this item back until no result is outstanding
  } pending_t;

  // DUT ports
  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Stimulus and expectations
  pending_t                 pending[$];
  out_item_t                expected_results[$];
  logic signed [DATA_W-1:0] planned_vals[$];  // queue contents as the stimulus plan sees them
  int                       items_queued = 0;

  // Predicted queue contents
  logic signed [DATA_W-1:0] model_cells[DEPTH];
  int                       model_fill = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_go  = 1'b0;
  bit          long_hold_taken;
  int          hold_left;
  int          err_count     = 0;
  int          quiet_cycles;

  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_xfer = out_valid_o && !out_stall_i;

  ordered_queue_delete_by_value #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= REPORT_MAX) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Work out the results of one accepted transfer and update the predicted queue
  function automatic void predict_results(input in_item_t it);
    out_item_t r;
    int        hit;
    r        = '0;
    r.status = ST_OK;
    r.last   = 1'b1;
    case (it.action)
      ACT_APPEND: begin
        if (model_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_cells[model_fill] = it.value;
          model_fill++;
        end
        expected_results.push_back(r);
      end
      ACT_DELETE: begin
        hit = -1;
        for (int i = 0; i < model_fill; i++)
          if (hit < 0 && model_cells[i] == it.value) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // close the gap behind the first match
          for (int i = hit; i + 1 < model_fill; i++) model_cells[i] = model_cells[i + 1];
          model_fill--;
        end
        expected_results.push_back(r);
      end
      ACT_READ: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < model_fill; i++) begin
            r.data = model_cells[i];
            r.last = (i == model_fill - 1);
            expected_results.push_back(r);
          end
        end
      end
      default: ;  // unused code: no result, no change
    endcase
  endfunction

  // Queue one item and track what the queue will hold once it is taken
  task automatic add_item(input action_e act, input logic signed [DATA_W-1:0] val,
                          input bit wait_drained);
    pending_t p;
    int       hit;
    p.item.action  = act;
    p.item.value   = val;
    p.wait_drained = wait_drained;
    pending.push_back(p);
    if (act != ACT_NONE) items_queued++;
    if (act == ACT_APPEND && planned_vals.size() < DEPTH) planned_vals.push_back(val);
    if (act == ACT_DELETE) begin
      hit = -1;
      for (int i = 0; i < planned_vals.size(); i++)
        if (hit < 0 && planned_vals[i] == val) hit = i;
      if (hit >= 0) planned_vals.delete(hit);
    end
  endtask

  // Values lean toward extremes and a small pool so duplicates and hits are common
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2, 3, 4: return DATA_W'(int'($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_present();
    if (planned_vals.size() == 0) return pick_value();
    return planned_vals[$urandom_range(planned_vals.size() - 1)];
  endfunction

  // Random part: fill-to-full, drain-to-empty and mixed episodes, with some noise
  task automatic add_random_batch(input int n, input bit pause_first);
    int target;
    int kind;
    target = items_queued + n;
    if (pause_first) add_item(ACT_READ, pick_value(), 1'b1);
    while (items_queued < target) begin
      kind = $urandom_range(9);
      if (kind <= 2) begin
        while (planned_vals.size() < DEPTH) add_item(ACT_APPEND, pick_value(), 1'b0);
        repeat ($urandom_range(1, 2)) add_item(ACT_APPEND, pick_value(), 1'b0);
        add_item(ACT_READ, pick_value(), 1'b0);
      end else if (kind <= 4) begin
        while (planned_vals.size() > 0) begin
          add_item(ACT_DELETE, pick_present(), 1'b0);
          if ($urandom_range(7) == 0) add_item(ACT_READ, pick_value(), 1'b0);
        end
        add_item(ACT_DELETE, pick_value(), 1'b0);
        add_item(ACT_READ, pick_value(), 1'b0);
      end else if (kind <= 8) begin
        repeat ($urandom_range(4, 12)) begin
          case ($urandom_range(5))
            0, 1: add_item(ACT_APPEND, pick_value(), 1'b0);
            2:    add_item(ACT_DELETE, pick_present(), 1'b0);
            // one bit away from a stored value: a near miss
            3:    add_item(ACT_DELETE, pick_present() ^ (DATA_W'(1) << $urandom_range(31)),
                           1'b0);
            4:    add_item(ACT_DELETE, pick_value(), 1'b0);
            default: add_item(ACT_READ, pick_value(), 1'b0);
          endcase
        end
      end else begin
        add_item(ACT_NONE, $urandom, 1'b0);
        add_item(ACT_DELETE, $urandom, 1'b0);
      end
    end
  endtask

  // Driver: offer pending items, predict on every accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    pending_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_xfer) predict_results(in_item_i);
      if (!(in_valid_i && in_stall_o)) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!pending[0].wait_drained || expected_results.size() == 0)) begin
          nxt = pending.pop_front();
          in_valid_i <= 1'b1;
          in_item_i  <= nxt.item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, drive the receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i     <= 1'b0;
      hold_left       = 0;
      long_hold_taken = 1'b0;
    end else begin
      if (out_xfer) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: data %0d status %0d last %0b",
                                    out_item_o.data, out_item_o.status, out_item_o.last));
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.data !== want.data)
            report_mismatch($sformatf("data %0d, expected %0d", out_item_o.data, want.data));
          if (out_item_o.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item_o.status, want.status));
          if (out_item_o.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_item_o.last, want.last));
        end
      end
      if (long_hold_go && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left       = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: no transfer on either side for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if (in_xfer || out_xfer) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ordered_queue_delete_by_value: mismatch");
        $finish;
      end
    end
  end

  // Sequencing
  initial begin
    send_idle_pct = 31;
    recv_idle_pct = 82;

    // empty queue cases
    add_item(ACT_READ,   32'sh0000_0000, 1'b0);
    add_item(ACT_DELETE, 32'sh0000_0000, 1'b0);
    // extremes, alternating bit patterns and a duplicate
    add_item(ACT_APPEND, 32'sh8000_0000, 1'b0);
    add_item(ACT_APPEND, 32'sh7FFF_FFFF, 1'b0);
    add_item(ACT_APPEND, 32'sh0000_0000, 1'b0);
    add_item(ACT_APPEND, 32'shFFFF_FFFF, 1'b0);
    add_item(ACT_APPEND, 32'sh5555_5555, 1'b0);
    add_item(ACT_APPEND, 32'shAAAA_AAAA, 1'b0);
    add_item(ACT_APPEND, 32'sh0000_0007, 1'b0);
    add_item(ACT_APPEND, 32'sh0000_0007, 1'b0);
    add_item(ACT_READ,   32'sh0000_0000, 1'b0);
    // first of two equal entries, near miss, head, middle
    add_item(ACT_DELETE, 32'sh0000_0007, 1'b0);
    add_item(ACT_DELETE, 32'sh7FFF_FFFE, 1'b0);
    add_item(ACT_DELETE, 32'sh8000_0000, 1'b0);
    add_item(ACT_DELETE, 32'shFFFF_FFFF, 1'b0);
    add_item(ACT_NONE,   32'shFFFF_FFFF, 1'b0);
    add_item(ACT_READ,   32'sh0000_0000, 1'b0);
    add_item(ACT_DELETE, 32'shFFFF_FFFF, 1'b0);
    // tail first, then empty out
    add_item(ACT_DELETE, 32'sh0000_0007, 1'b0);
    add_item(ACT_DELETE, 32'sh7FFF_FFFF, 1'b0);
    add_item(ACT_DELETE, 32'sh0000_0000, 1'b0);
    add_item(ACT_DELETE, 32'sh5555_5555, 1'b0);
    add_item(ACT_DELETE, 32'shAAAA_AAAA, 1'b0);
    add_item(ACT_READ,   32'sh0000_0000, 1'b0);
    add_random_batch(130, 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sparse sender, busy receiver; the batch opens with a pause until drained
    while (pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_idle_pct = 82;
    recv_idle_pct = 31;
    add_random_batch(140, 1'b1);

    // no idling, opened by a long receiver hold-off against a steady sender
    while (pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_go  = 1'b1;
    add_random_batch(140, 1'b0);

    while (pending.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("ordered_queue_delete_by_value: match");
    end else begin
      $display("ordered_queue_delete_by_value: mismatch");
    end
    $finish;
  end

endmodule
